@@ hdl/fpp_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the framed packet parser.
// Used by the front, queue, back and top-level modules; depends on nothing.
package fpp_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [7:0]  SyncFirst  = 8'hA2;
  localparam logic [7:0]  SyncSecond = 8'hA5;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] CrcStart   = 16'h0000;
  localparam logic [15:0] LimitReset = 16'd256;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SYNC1,
    PH_SYNC2,
    PH_CMD0,
    PH_CMD1,
    PH_LEN0,
    PH_LEN1,
    PH_CRC0,
    PH_BODY
  } phase_e;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_OK         = 2'd1,
    ST_BAD        = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_PLAIN,
    OP_ZERO_LEN,
    OP_BODY
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        last;
    logic [7:0]  data;
    logic [15:0] index;
    logic [15:0] command;
    logic [15:0] length;
    logic [15:0] rcheck;
  } work_t;

  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/framed_packet_parser_crc16.sv @@
// Framed packet parser with running CRC-16: one byte per cycle unless the output stalls.
// An accepted byte is written into the queue, then registered at the outputs when popped.
// A two-entry queue separates the header front from the CRC back; each stalls alone.
// Reset is asynchronous, active low: hunting state, empty queue, length limit 256.
// Top level; instantiates fpp_front, fpp_queue and fpp_back, uses fpp_pkg.
module framed_packet_parser_crc16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  frame_status_o,
  output logic [15:0] frame_command_o,
  output logic [15:0] frame_length_o,
  output logic        payload_valid_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  payload_byte_o
);
  import fpp_pkg::*;

  work_t push_item, pop_item;
  logic  push, full, q_valid, pop;

  fpp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  fpp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  fpp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .item_i          (pop_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_status_o  (frame_status_o),
    .frame_command_o (frame_command_o),
    .frame_length_o  (frame_length_o),
    .payload_valid_o (payload_valid_o),
    .payload_index_o (payload_index_o),
    .payload_byte_o  (payload_byte_o)
  );

endmodule

@@ hdl/fpp_front.sv @@
// Front part of the parser: accepts bytes, tracks the frame phase and header words.
// Classifies each byte into a work item for the queue; depends on fpp_pkg.
module fpp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    rx_byte_i,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          full_i,
  output logic          push_o,
  output fpp_pkg::work_t item_o
);
  import fpp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] command_q, command_d;
  logic [15:0] length_q, length_d;
  logic [15:0] rcheck_q, rcheck_d;
  logic [15:0] count_q, count_d;
  logic [15:0] limit_q;
  logic        accept;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_SYNC1: phase_d = (rx_byte_i == SyncSecond) ? PH_SYNC2 : PH_IDLE;
      PH_SYNC2: phase_d = PH_CMD0;
      PH_CMD0:  phase_d = PH_CMD1;
      PH_CMD1:  phase_d = PH_LEN0;
      PH_LEN0:  phase_d = (length_d > limit_q) ? PH_IDLE : PH_LEN1;
      PH_LEN1:  phase_d = PH_CRC0;
      PH_CRC0:  phase_d = (length_q == 16'd0) ? PH_IDLE : PH_BODY;
      PH_BODY:  phase_d = (count_d == length_q) ? PH_IDLE : PH_BODY;
      default:  phase_d = (rx_byte_i == SyncFirst) ? PH_SYNC1 : PH_IDLE;
    endcase
  end

  always_comb begin
    command_d = command_q;
    length_d  = length_q;
    rcheck_d  = rcheck_q;
    count_d   = count_q;
    item_o.op    = OP_PLAIN;
    item_o.last  = 1'b0;
    item_o.data  = rx_byte_i;
    item_o.index = count_q;
    unique case (phase_q)
      PH_SYNC2: command_d = {8'h00, rx_byte_i};
      PH_CMD0:  command_d = {rx_byte_i, command_q[7:0]};
      PH_CMD1:  length_d  = {8'h00, rx_byte_i};
      PH_LEN0:  length_d  = {rx_byte_i, length_q[7:0]};
      PH_LEN1:  rcheck_d  = {8'h00, rx_byte_i};
      PH_CRC0: begin
        rcheck_d = {rx_byte_i, rcheck_q[7:0]};
        count_d  = 16'd0;
        if (length_q == 16'd0) begin
          item_o.op   = OP_ZERO_LEN;
          item_o.last = 1'b1;
        end
      end
      PH_BODY: begin
        count_d     = count_q + 16'd1;
        item_o.op   = OP_BODY;
        item_o.last = (count_d == length_q);
      end
      default: ;
    endcase
    item_o.command = command_d;
    item_o.length  = length_d;
    item_o.rcheck  = rcheck_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      command_q <= 16'd0;
      length_q  <= 16'd0;
      rcheck_q  <= 16'd0;
      count_q   <= 16'd0;
    end else if (accept) begin
      phase_q   <= phase_d;
      command_q <= command_d;
      length_q  <= length_d;
      rcheck_q  <= rcheck_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

endmodule

@@ hdl/fpp_queue.sv @@
// Short FIFO of classified work items between the parser front and back.
// Depth is set by QueueDepth in fpp_pkg.
module fpp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpp_pkg::work_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fpp_pkg::work_t item_o
);
  import fpp_pkg::*;

  work_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  count_q;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("Queue count exceeds its depth.");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !pop_i)
    else $error("Queue popped while empty.");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("Queue pushed while full.");
`endif

endmodule

@@ hdl/fpp_back.sv @@
// Back part of the parser: runs the CRC-16 over payload items and forms the result.
// Holds the output register; depends on fpp_pkg.
module fpp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  fpp_pkg::work_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     frame_status_o,
  output logic [15:0]    frame_command_o,
  output logic [15:0]    frame_length_o,
  output logic           payload_valid_o,
  output logic [15:0]    payload_index_o,
  output logic [7:0]     payload_byte_o
);
  import fpp_pkg::*;

  logic        out_valid_q;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_base;
  status_e     status_q, status_d;
  logic [15:0] command_q, length_q, index_q, index_d;
  logic        pvalid_q, pvalid_d;
  logic [7:0]  byte_q, byte_d;

  assign pop_o = valid_i && (!out_valid_q || !out_stall_i);

  assign crc_base = (item_i.index == 16'd0) ? CrcStart : crc_q;

  always_comb begin
    crc_d    = crc_q;
    status_d = ST_INCOMPLETE;
    pvalid_d = 1'b0;
    index_d  = 16'd0;
    byte_d   = 8'h00;
    unique case (item_i.op)
      OP_ZERO_LEN: status_d = (item_i.rcheck == CrcStart) ? ST_OK : ST_BAD;
      OP_BODY: begin
        crc_d    = crc_add_byte(crc_base, item_i.data);
        pvalid_d = 1'b1;
        index_d  = item_i.index;
        byte_d   = item_i.data;
        if (item_i.last) begin
          status_d = (crc_d == item_i.rcheck) ? ST_OK : ST_BAD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= CrcStart;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        crc_q       <= crc_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q  <= status_d;
      command_q <= item_i.command;
      length_q  <= item_i.length;
      pvalid_q  <= pvalid_d;
      index_q   <= index_d;
      byte_q    <= byte_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_status_o  = status_q;
  assign frame_command_o = command_q;
  assign frame_length_o  = length_q;
  assign payload_valid_o = pvalid_q;
  assign payload_index_o = index_q;
  assign payload_byte_o  = byte_q;

`ifndef SYNTH
  a_plain_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.op == OP_PLAIN) |=> (status_q == ST_INCOMPLETE && !pvalid_q))
    else $error("Header item produced a payload or final status.");
  a_idle_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pvalid_q) |-> (index_q == 16'd0 && byte_q == 8'h00))
    else $error("Non-payload item carries payload fields.");
  a_status_final_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !item_i.last) |=> (status_q == ST_INCOMPLETE))
    else $error("Final status on an item that does not end a frame.");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for framed_packet_parser_crc16: byte stream in, one parse result per byte out.
// It predicts each result from its own model of the framer and CRC and compares every field.
// Depends on fpp_pkg and the framed_packet_parser_crc16 RTL.
`timescale 1ns / 100ps

module testbench;
  import fpp_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned TargetBytes = 1150;
  localparam int unsigned DrainCycles = 4;

  typedef logic [7:0] byte_list_t[];

  typedef struct {
    status_e     status;
    logic [15:0] command;
    logic [15:0] length;
    logic        pvalid;
    logic [15:0] pindex;
    logic [7:0]  pbyte;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  frame_status;
  logic [15:0] frame_command;
  logic [15:0] frame_length;
  logic        payload_valid;
  logic [15:0] payload_index;
  logic [7:0]  payload_byte;

  phase_e      model_phase = PH_IDLE;
  logic [15:0] model_cmd = 16'h0000;
  logic [15:0] model_len = 16'h0000;
  logic [15:0] model_rcheck = 16'h0000;
  logic [15:0] model_crc = CrcStart;
  logic [15:0] model_count = 16'h0000;
  logic [15:0] model_limit = LimitReset;

  parse_result_t result_q[$];

  bit          idle_enable = 1'b1;
  bit          stall_enable = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned failures = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned frame_bytes = 0;
  int unsigned frames_good = 0;
  int unsigned frames_bad = 0;
  int unsigned payload_seen = 0;
  int unsigned limits_written = 0;

  framed_packet_parser_crc16 dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .frame_status_o  (frame_status),
    .frame_command_o (frame_command),
    .frame_length_o  (frame_length),
    .payload_valid_o (payload_valid),
    .payload_index_o (payload_index),
    .payload_byte_o  (payload_byte)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    parse_result_t r;
    r.status = ST_INCOMPLETE;
    r.pvalid = 1'b0;
    r.pindex = 16'h0000;
    r.pbyte = 8'h00;
    case (model_phase)
      PH_SYNC1: begin
        model_phase = (b == SyncSecond) ? PH_SYNC2 : PH_IDLE;
      end
      PH_SYNC2: begin
        model_cmd = {8'h00, b};
        model_phase = PH_CMD0;
      end
      PH_CMD0: begin
        model_cmd[15:8] = b;
        model_phase = PH_CMD1;
      end
      PH_CMD1: begin
        model_len = {8'h00, b};
        model_phase = PH_LEN0;
      end
      PH_LEN0: begin
        model_len[15:8] = b;
        model_phase = (model_len > model_limit) ? PH_IDLE : PH_LEN1;
      end
      PH_LEN1: begin
        model_rcheck = {8'h00, b};
        model_phase = PH_CRC0;
      end
      PH_CRC0: begin
        model_rcheck[15:8] = b;
        model_count = 16'h0000;
        model_crc = CrcStart;
        model_phase = PH_BODY;
        if (model_len == 16'h0000) begin
          r.status = (model_rcheck == CrcStart) ? ST_OK : ST_BAD;
          model_phase = PH_IDLE;
        end
      end
      PH_BODY: begin
        r.pvalid = 1'b1;
        r.pindex = model_count;
        r.pbyte = b;
        model_crc = crc16_update(model_crc, b);
        model_count = model_count + 16'd1;
        payload_seen++;
        if (model_count == model_len) begin
          r.status = (model_crc == model_rcheck) ? ST_OK : ST_BAD;
          model_phase = PH_IDLE;
        end
      end
      default: begin
        model_phase = (b == SyncFirst) ? PH_SYNC1 : PH_IDLE;
      end
    endcase
    if (r.status == ST_OK) frames_good++;
    if (r.status == ST_BAD) frames_bad++;
    r.command = model_cmd;
    r.length = model_len;
    result_q.push_back(r);
  endfunction

  function automatic void check_result();
    parse_result_t e;
    results_checked++;
    if (result_q.size() == 0) begin
      failures++;
      if (failures <= MaxReports) begin
        $display("unexpected result: status %0d command %h length %h",
                 frame_status, frame_command, frame_length);
      end
      return;
    end
    e = result_q.pop_front();
    if (frame_status !== e.status || frame_command !== e.command ||
        frame_length !== e.length || payload_valid !== e.pvalid ||
        payload_index !== e.pindex || payload_byte !== e.pbyte) begin
      failures++;
      if (failures <= MaxReports) begin
        $display("mismatch at result %0d: expected status %0d cmd %h len %h pv %b idx %0d byte %h,",
                 results_checked, e.status, e.command, e.length, e.pvalid, e.pindex, e.pbyte);
        $display("  actual status %0d cmd %h len %h pv %b idx %0d byte %h",
                 frame_status, frame_command, frame_length, payload_valid, payload_index,
                 payload_byte);
      end
    end
  endfunction

  function automatic int unsigned pick_idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic byte_list_t random_body(input int unsigned n);
    byte_list_t b;
    b = new[n];
    foreach (b[i]) b[i] = 8'($urandom_range(0, 255));
    return b;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (!stall_enable) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_idle_length() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("cycle limit of %0d reached with %0d results outstanding",
               CycleLimit, result_q.size());
      $display("framed_packet_parser_crc16 test failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 3) == 0) gap = pick_idle_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_length_limit(input logic [15:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_limit = value;
    limits_written++;
  endtask

  task automatic send_header(input logic [15:0] cmd, input logic [15:0] len);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(cmd[7:0]);
    send_byte(cmd[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  task automatic send_frame(input logic [15:0] cmd, input byte_list_t body,
                            input logic [15:0] crc_flip);
    logic [15:0] crc;
    crc = CrcStart;
    foreach (body[i]) crc = crc16_update(crc, body[i]);
    crc = crc ^ crc_flip;
    send_header(cmd, 16'(body.size()));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    foreach (body[i]) send_byte(body[i]);
    frame_bytes += 8 + body.size();
  endtask

  task automatic send_random_unit();
    int unsigned kind;
    int unsigned cap;
    int unsigned len;
    int unsigned over;
    logic [7:0]  second;
    kind = $urandom_range(0, 99);
    cap = (model_limit < 24) ? model_limit : 24;
    if (kind >= 78 && kind < 86 && model_limit != 16'hFFFF) begin
      over = 32'(model_limit) + $urandom_range(1, 300);
      if (over > 65535) over = 65535;
      send_header(16'($urandom), 16'(over));
    end else if (kind >= 86 && kind < 92) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end else if (kind >= 92 && kind < 96) begin
      second = 8'($urandom_range(0, 255));
      if (second == SyncSecond) second = SyncFirst;
      send_byte(SyncFirst);
      send_byte(second);
    end else if (kind >= 96 && model_limit != 16'hFFFF) begin
      send_byte(SyncFirst);
      send_byte(SyncSecond);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      if (kind < 70) len = $urandom_range(0, cap);
      else if (model_limit <= 64) len = model_limit;
      else len = $urandom_range(25, 64);
      send_frame(16'($urandom), random_body(len),
                 ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000);
    end
  endtask

  task automatic test_special_cases();
    byte_list_t no_body;
    send_frame(16'h0000, no_body, 16'h0000);
    send_frame(16'hFFFF, no_body, 16'hFFFF);
    send_byte(SyncFirst);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_header(16'h1234, LimitReset + 16'd1);
  endtask

  task automatic test_length_limit();
    byte_list_t no_body;
    write_length_limit(16'd3);
    send_frame(16'($urandom), random_body(3), 16'h0000);
    send_header(16'($urandom), 16'd4);
    write_length_limit(16'd0);
    send_frame(16'($urandom), no_body, 16'h0000);
    send_header(16'($urandom), 16'd1);
    write_length_limit(16'hFFFF);
    send_frame(16'($urandom), random_body(300), 16'h0000);
    send_frame(16'($urandom), random_body(2), 16'h0001);
  endtask

  task automatic test_back_to_back();
    wait_drained();
    idle_enable = 1'b0;
    stall_enable = 1'b0;
    repeat (8) send_frame(16'($urandom), random_body($urandom_range(0, 12)), 16'h0000);
    wait_drained();
    idle_enable = 1'b1;
    stall_enable = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [15:0] limits[4];
    int unsigned stop;
    int unsigned budget;
    bit          held;
    limits[0] = LimitReset;
    limits[1] = 16'($urandom_range(8, 64));
    limits[2] = 16'hFFFF;
    limits[3] = 16'($urandom_range(1, 7));
    held = 1'b0;
    budget = (bytes_sent < TargetBytes) ? (TargetBytes - bytes_sent) / 4 : 0;
    for (int p = 0; p < 4; p++) begin
      write_length_limit(limits[p]);
      stop = bytes_sent + budget;
      while (bytes_sent < stop) begin
        send_random_unit();
        if (p == 1 && !held && bytes_sent + budget / 2 >= stop) begin
          wait_drained();
          held = 1'b1;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_length_limit();
    test_back_to_back();
    test_random_traffic();
    wait_drained();
    $display("Sent %0d bytes (%0d in well-formed frames): %0d good-CRC and %0d bad-CRC frames",
             bytes_sent, frame_bytes, frames_good, frames_bad);
    $display("Checked %0d results with %0d payload bytes over %0d length limits, %0d failures",
             results_checked, payload_seen, limits_written, failures);
    if (failures == 0 && result_q.size() == 0) begin
      $display("framed_packet_parser_crc16 test passed");
    end else begin
      $display("framed_packet_parser_crc16 test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/fpp_pkg.sv
hdl/fpp_front.sv
hdl/fpp_queue.sv
hdl/fpp_back.sv
hdl/framed_packet_parser_crc16.sv
tb/testbench.sv
